### sv/gw5_pkg.sv
`timescale 1ns / 1ps

package gw5_pkg;

  localparam int PIX_W   = 8;
  localparam int COLS_W  = 11;
  localparam int ROWS_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 1;
  localparam int WIN     = 5;
  localparam int NLANES  = 4;
  localparam int VSUM_W  = 12;
  localparam int HSUM_W  = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [CFG_IW-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_ROWS = 1'b1;

  localparam logic [COLS_W-1:0] COLS_RST = 11'd640;
  localparam logic [ROWS_W-1:0] ROWS_RST = 16'd480;

  // One padded input pixel as seen by the back end: the full window column
  // (oldest row first) plus its classification.
  typedef struct packed {
    logic [WIN-1:0][PIX_W-1:0] pix;
    logic                      emit;
    logic                      last;
  } col_t;

endpackage

### sv/gaussian_5x5_window_filter_unit.sv
`timescale 1ns / 1ps

// 5x5 binomial (1-4-6-4-1) blur over a border-padded frame of (out_cols+4) x
// (out_rows+4) 8-bit pixels in raster order; one result per full window, in
// raster order, frame_end on the frame's last result. Sustains one pixel per
// clock while the column queue has room: the line stores are single-port per
// row lane and the sum is a fixed separable shift-add tree. A 4-entry column
// queue sits between the line-store front end and the filter back end. Writing
// either register restarts the frame; the line stores need no initialization,
// as unwritten entries never reach a result.
module gaussian_5x5_window_filter_unit #(
  parameter int MAX_COLS = 2044
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gw5_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [gw5_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gw5_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gw5_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                          frame_end_o
);
  import gw5_pkg::*;

  logic               push, pop, not_empty;
  col_t               push_data, head;
  logic [FIFO_CW-1:0] fifo_count;

  gw5_front #(
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .fifo_count_i(fifo_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  gw5_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .not_empty_o(not_empty),
    .count_o    (fifo_count)
  );

  gw5_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .not_empty_i(not_empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o),
    .frame_end_o(frame_end_o)
  );

endmodule

### sv/gw5_fifo.sv
`timescale 1ns / 1ps

module gw5_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  gw5_pkg::col_t          push_data_i,
  input  logic                   pop_i,
  output gw5_pkg::col_t          head_o,
  output logic                   not_empty_o,
  output logic [gw5_pkg::FIFO_CW-1:0] count_o
);
  import gw5_pkg::*;

  col_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d;
  logic [FIFO_AW-1:0] rd_q, rd_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               do_pop;

  assign do_pop      = pop_i && (cnt_q != '0);
  assign not_empty_o = (cnt_q != '0);
  assign count_o     = cnt_q;
  assign head_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### sv/gw5_front.sv
`timescale 1ns / 1ps

module gw5_front #(
  parameter int MAX_COLS = 2044
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gw5_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [gw5_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gw5_pkg::PIX_W-1:0]     pixel_in_i,
  input  logic [gw5_pkg::FIFO_CW-1:0]   fifo_count_i,
  output logic                          push_o,
  output gw5_pkg::col_t                 push_data_o
);
  import gw5_pkg::*;

  localparam int LINE_LEN = MAX_COLS + 4;
  localparam int AW       = $clog2(LINE_LEN);

  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] col_q, col_d;
  logic [ROWS_W-1:0] row_q, row_d;

  logic [COLS_W-1:0] eff_cols;
  logic [ROWS_W-1:0] eff_rows;
  logic [COLS_W:0]   in_cols;
  logic [ROWS_W:0]   in_rows;
  logic [COLS_W-1:0] c_use;
  logic [ROWS_W-1:0] r_use;
  logic [COLS_W:0]   c_inc;
  logic [ROWS_W:0]   r_inc;
  logic              emit, last, accept;

  logic [COLS_W+AW-1:0] c_ext;
  logic [AW-1:0]        addr;

  logic [PIX_W-1:0]  rd_q [NLANES];
  logic [PIX_W-1:0]  px_q;
  logic [1:0]        sel_q;
  logic              emit_q, last_q, s1_valid_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = ({1'b0, fifo_count_i} + {{FIFO_CW{1'b0}}, s1_valid_q})
                      < (FIFO_CW + 1)'(FIFO_DEPTH);

  always_comb begin
    eff_cols = cols_q;
    if (cols_q == '0) begin
      eff_cols = COLS_W'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      eff_cols = COLS_W'(MAX_COLS);
    end
    eff_rows = (rows_q == '0) ? ROWS_W'(1) : rows_q;
    in_cols  = {1'b0, eff_cols} + (COLS_W + 1)'(4);
    in_rows  = {1'b0, eff_rows} + (ROWS_W + 1)'(4);
    c_use    = ({1'b0, col_q} >= in_cols) ? '0 : col_q;
    r_use    = ({1'b0, row_q} >= in_rows) ? '0 : row_q;
    emit     = (r_use >= ROWS_W'(4)) && (c_use >= COLS_W'(4));
    last     = ({1'b0, r_use} == in_rows - 1'b1) && ({1'b0, c_use} == in_cols - 1'b1);
    c_inc    = {1'b0, c_use} + 1'b1;
    r_inc    = {1'b0, r_use} + 1'b1;
    col_d    = c_inc[COLS_W-1:0];
    row_d    = r_use;
    if (c_inc >= in_cols) begin
      col_d = '0;
      row_d = (r_inc >= in_rows) ? '0 : r_inc[ROWS_W-1:0];
    end
  end

  assign c_ext = {{AW{1'b0}}, c_use};
  assign addr  = c_ext[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= COLS_RST;
      rows_q     <= ROWS_RST;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLS: cols_q <= cfg_data_i[COLS_W-1:0];
          CFG_ROWS: rows_q <= cfg_data_i[ROWS_W-1:0];
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Four line stores, one per row modulo 4; read before write at the same column.
  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    logic [PIX_W-1:0] mem [LINE_LEN];
    always_ff @(posedge clk_i) begin
      if (accept) begin
        rd_q[l] <= mem[addr];
        if (r_use[1:0] == 2'(l)) begin
          mem[addr] <= pixel_in_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= pixel_in_i;
      sel_q  <= r_use[1:0];
      emit_q <= emit;
      last_q <= last;
    end
  end

  always_comb begin
    push_data_o.pix[WIN-1] = px_q;
    for (int i = 0; i < NLANES; i++) begin
      push_data_o.pix[i] = rd_q[sel_q + 2'(i)];
    end
    push_data_o.emit = emit_q;
    push_data_o.last = last_q;
  end

  assign push_o = s1_valid_q;

endmodule

### sv/gw5_back.sv
`timescale 1ns / 1ps

module gw5_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      not_empty_i,
  input  gw5_pkg::col_t             head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [gw5_pkg::PIX_W-1:0] pixel_out_o,
  output logic                      frame_end_o
);
  import gw5_pkg::*;

  logic [VSUM_W-1:0] taps_q [WIN];
  logic [VSUM_W-1:0] vsum;
  logic [HSUM_W-1:0] hsum;
  logic [PIX_W-1:0]  res;
  logic              hv_q, hlast_q;
  logic              out_valid_q, out_last_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_free, adv_h;

  // Separable 1-4-6-4-1: vertical sum per column, horizontal sum over taps.
  always_comb begin
    vsum = VSUM_W'(head_i.pix[0]) + VSUM_W'(head_i.pix[4])
         + ((VSUM_W'(head_i.pix[1]) + VSUM_W'(head_i.pix[3])) << 2)
         + (VSUM_W'(head_i.pix[2]) << 2) + (VSUM_W'(head_i.pix[2]) << 1);
    hsum = HSUM_W'(taps_q[0]) + HSUM_W'(taps_q[4])
         + ((HSUM_W'(taps_q[1]) + HSUM_W'(taps_q[3])) << 2)
         + (HSUM_W'(taps_q[2]) << 2) + (HSUM_W'(taps_q[2]) << 1);
    res  = hsum[HSUM_W-1:HSUM_W-PIX_W];
    if (res == '0) begin
      res = PIX_W'(1);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign adv_h    = !hv_q || out_free;
  assign pop_o    = not_empty_i && adv_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        hv_q <= head_i.emit;
      end else if (adv_h) begin
        hv_q <= 1'b0;
      end
      if (hv_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < WIN - 1; i++) begin
        taps_q[i] <= taps_q[i+1];
      end
      taps_q[WIN-1] <= vsum;
      hlast_q       <= head_i.last;
    end
    if (hv_q && out_free) begin
      out_pix_q  <= res;
      out_last_q <= hlast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign frame_end_o = out_last_q;

endmodule
